### hw/rtl/afd_pkg.sv
// Package for the ASCII frame deframer: character codes, event codes, counter slots,
// the byte-wide CRC-16/CCITT-FALSE update and the hex digit decode.
// No dependencies.
package afd_pkg;

   localparam int MAX_LEN = 256;
   localparam int COUNT_W = $clog2(MAX_LEN);
   localparam int DELAY   = 7;
   localparam int NUM_CNT = 5;

   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int CNT_VALID    = 0;
   localparam int CNT_CRC      = 1;
   localparam int CNT_FORMAT   = 2;
   localparam int CNT_OVERFLOW = 3;
   localparam int CNT_DROPPED  = 4;

   typedef enum logic [2:0] {
      EV_DROPPED   = 3'd0,
      EV_START     = 3'd1,
      EV_STORED    = 3'd2,
      EV_RESTART   = 3'd3,
      EV_OVERFLOW  = 3'd4,
      EV_VALID     = 3'd5,
      EV_CRC_ERR   = 3'd6,
      EV_FORMAT    = 3'd7
   } evt_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // {ok, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
      else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
      else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
      return r;
   endfunction

endpackage

### hw/rtl/ascii_frame_deframer_crc16_unit.sv
// Top level of the ASCII frame deframer with CRC-16/CCITT-FALSE check.
// Depends on afd_pkg.
//
// One received byte per transaction on req_, one result transaction per byte on rsp_.
// Each byte is handled combinationally: frame state, seven-byte delay line, byte-wide
// CRC update and tail check sit between the state registers and one result register, so
// a byte is accepted every cycle req_stall is low, and its result appears in the next
// cycle. req_stall is high only while the result register is full and rsp_stall holds it.
// The five totals are the wrapping counters after the byte of the result shown.
module ascii_frame_deframer_crc16_unit
   import afd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_body_len,
   output logic [15:0] rsp_crc_rx,
   output logic [15:0] rsp_crc_calc,
   output logic [31:0] rsp_valid_total,
   output logic [31:0] rsp_crc_error_total,
   output logic [31:0] rsp_format_error_total,
   output logic [31:0] rsp_overflow_total,
   output logic [31:0] rsp_dropped_total
);

   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         tail_ff [DELAY];
   logic [7:0]         tail_in [DELAY];
   logic [7:0]         shifted [DELAY];
   logic [15:0]        crc_ff, crc_in;
   logic [31:0]        cnt_ff [NUM_CNT];
   logic [31:0]        cnt_in [NUM_CNT];

   logic        rsp_valid_ff;
   evt_type     ev_ff, ev_in;
   logic        pv_ff, pv_in;
   logic [7:0]  pb_ff, pb_in;
   logic [7:0]  pidx_ff, pidx_in;
   logic [7:0]  plen_ff, plen_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [15:0] ccrc_ff, ccrc_in;

   logic               req_accept;
   logic [COUNT_W-1:0] held;
   logic [4:0]         d1, d2, d3, d4;
   logic               tail_ok;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign held       = count_ff - COUNT_W'(1);

   always_comb begin
      for (int i = 0; i < DELAY - 1; i++) shifted[i] = tail_ff[i+1];
      shifted[DELAY-1] = req_rx_byte;
   end

   assign d1 = hex_digit(shifted[1]);
   assign d2 = hex_digit(shifted[2]);
   assign d3 = hex_digit(shifted[3]);
   assign d4 = hex_digit(shifted[4]);
   assign tail_ok = (count_ff + COUNT_W'(1) >= COUNT_W'(9)) && shifted[0] == CH_STAR &&
                    shifted[5] == CH_CR && d1[4] && d2[4] && d3[4] && d4[4];

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      tail_in     = tail_ff;
      crc_in      = crc_ff;
      cnt_in      = cnt_ff;
      ev_in       = EV_DROPPED;
      pv_in       = 1'b0;
      pb_in       = 8'd0;
      pidx_in     = 8'd0;
      plen_in     = 8'd0;
      rcrc_in     = 16'd0;
      ccrc_in     = 16'd0;
      if (!in_frame_ff) begin
         if (req_rx_byte == CH_AT) begin
            in_frame_in = 1'b1;
            count_in    = COUNT_W'(1);
            for (int i = 0; i < DELAY; i++) tail_in[i] = 8'd0;
            crc_in      = CRC_INIT;
            ev_in       = EV_START;
         end else begin
            cnt_in[CNT_DROPPED] = cnt_ff[CNT_DROPPED] + 32'd1;
         end
      end else if (req_rx_byte == CH_AT) begin
         cnt_in[CNT_FORMAT] = cnt_ff[CNT_FORMAT] + 32'd1;
         count_in = COUNT_W'(1);
         for (int i = 0; i < DELAY; i++) tail_in[i] = 8'd0;
         crc_in   = CRC_INIT;
         ev_in    = EV_RESTART;
      end else if (count_ff >= COUNT_W'(MAX_LEN - 1)) begin
         cnt_in[CNT_OVERFLOW] = cnt_ff[CNT_OVERFLOW] + 32'd1;
         in_frame_in = 1'b0;
         count_in    = '0;
         ev_in       = EV_OVERFLOW;
      end else begin
         if (held >= COUNT_W'(DELAY)) begin
            pv_in   = 1'b1;
            pb_in   = tail_ff[0];
            pidx_in = 8'(held - COUNT_W'(DELAY));
            crc_in  = crc16_byte(crc_ff, tail_ff[0]);
         end
         tail_in  = shifted;
         count_in = count_ff + COUNT_W'(1);
         ev_in    = EV_STORED;
         if (req_rx_byte == CH_LF) begin
            if (tail_ok) begin
               plen_in = 8'(count_in - COUNT_W'(8));
               rcrc_in = {d1[3:0], d2[3:0], d3[3:0], d4[3:0]};
               ccrc_in = crc_in;
               if (rcrc_in == crc_in) begin
                  cnt_in[CNT_VALID] = cnt_ff[CNT_VALID] + 32'd1;
                  ev_in = EV_VALID;
               end else begin
                  cnt_in[CNT_CRC] = cnt_ff[CNT_CRC] + 32'd1;
                  ev_in = EV_CRC_ERR;
               end
            end else begin
               cnt_in[CNT_FORMAT] = cnt_ff[CNT_FORMAT] + 32'd1;
               ev_in = EV_FORMAT;
            end
            in_frame_in = 1'b0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < DELAY; i++) tail_ff[i] <= 8'd0;
         crc_ff       <= CRC_INIT;
         for (int i = 0; i < NUM_CNT; i++) cnt_ff[i] <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            in_frame_ff  <= in_frame_in;
            count_ff     <= count_in;
            tail_ff      <= tail_in;
            crc_ff       <= crc_in;
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ev_ff   <= ev_in;
         pv_ff   <= pv_in;
         pb_ff   <= pb_in;
         pidx_ff <= pidx_in;
         plen_ff <= plen_in;
         rcrc_ff <= rcrc_in;
         ccrc_ff <= ccrc_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_res          = ev_ff;
   assign rsp_payload_valid      = pv_ff;
   assign rsp_payload_byte       = pb_ff;
   assign rsp_payload_index      = pidx_ff;
   assign rsp_body_len           = plen_ff;
   assign rsp_crc_rx             = rcrc_ff;
   assign rsp_crc_calc           = ccrc_ff;
   assign rsp_valid_total        = cnt_ff[CNT_VALID];
   assign rsp_crc_error_total    = cnt_ff[CNT_CRC];
   assign rsp_format_error_total = cnt_ff[CNT_FORMAT];
   assign rsp_overflow_total     = cnt_ff[CNT_OVERFLOW];
   assign rsp_dropped_total      = cnt_ff[CNT_DROPPED];

`ifndef SYNTH
   a_pv_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pv_ff |-> ev_ff == EV_STORED || ev_ff == EV_VALID ||
                                ev_ff == EV_CRC_ERR || ev_ff == EV_FORMAT)
      else $error("payload byte reported on a non-storing event");

   a_close_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ev_ff != EV_VALID && ev_ff != EV_CRC_ERR |->
         plen_ff == 8'd0 && rcrc_ff == 16'd0 && ccrc_ff == 16'd0)
      else $error("close fields set outside a checked close");

   a_valid_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ev_ff == EV_VALID |-> rcrc_ff == ccrc_ff)
      else $error("valid frame with mismatching CRC");

   a_dropped_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && !in_frame_ff && req_rx_byte != CH_AT |=>
         cnt_ff[CNT_DROPPED] == $past(cnt_ff[CNT_DROPPED]) + 32'd1)
      else $error("dropped byte not counted");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> count_ff == '0)
      else $error("frame count non-zero while idle");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for ascii_frame_deframer_crc16_unit: byte predictor, checker, frame stimulus.
// Depends on afd_pkg and the deframer RTL.
module tb;
   import afd_pkg::*;

   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      evt_type     ev;
      logic        pv;
      logic [7:0]  pbyte;
      logic [7:0]  pidx;
      logic [7:0]  plen;
      logic [15:0] rcrc;
      logic [15:0] ccrc;
      logic [31:0] n_valid;
      logic [31:0] n_crc;
      logic [31:0] n_format;
      logic [31:0] n_ovf;
      logic [31:0] n_drop;
   } frame_result_type;

   typedef enum int {
      FLAW_NONE,
      FLAW_CRC,
      FLAW_STAR,
      FLAW_HEX,
      FLAW_CR,
      FLAW_RESTART,
      FLAW_SHORT
   } flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [7:0]  rsp_body_len;
   logic [15:0] rsp_crc_rx;
   logic [15:0] rsp_crc_calc;
   logic [31:0] rsp_valid_total;
   logic [31:0] rsp_crc_error_total;
   logic [31:0] rsp_format_error_total;
   logic [31:0] rsp_overflow_total;
   logic [31:0] rsp_dropped_total;

   // predictor state
   logic        in_frame_m = 1'b0;
   int unsigned frame_len = 0;
   logic [7:0]  tail_q [DELAY];
   logic [15:0] crc_acc = CRC_INIT;
   logic [31:0] tally [NUM_CNT];

   frame_result_type due_results[$];
   int mismatches = 0;
   int items_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;

   ascii_frame_deframer_crc16_unit u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_event_res          (rsp_event_res),
      .rsp_payload_valid      (rsp_payload_valid),
      .rsp_payload_byte       (rsp_payload_byte),
      .rsp_payload_index      (rsp_payload_index),
      .rsp_body_len           (rsp_body_len),
      .rsp_crc_rx             (rsp_crc_rx),
      .rsp_crc_calc           (rsp_crc_calc),
      .rsp_valid_total        (rsp_valid_total),
      .rsp_crc_error_total    (rsp_crc_error_total),
      .rsp_format_error_total (rsp_format_error_total),
      .rsp_overflow_total     (rsp_overflow_total),
      .rsp_dropped_total      (rsp_dropped_total)
   );

   always #5 clock = ~clock;

   // bit-serial form of the CCITT-FALSE update
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         logic fb;
         fb = r[15] ^ b[i];
         r = {r[14:0], 1'b0};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic int hex_val(input logic [7:0] ch);
      if (ch inside {[8'h30:8'h39]}) return int'(ch) - 'h30;
      if (ch inside {[8'h41:8'h46]}) return int'(ch) - 'h37;
      if (ch inside {[8'h61:8'h66]}) return int'(ch) - 'h57;
      return -1;
   endfunction

   function automatic void open_frame();
      in_frame_m = 1'b1;
      frame_len = 1;
      foreach (tail_q[i]) tail_q[i] = 8'h00;
      crc_acc = CRC_INIT;
   endfunction

   function automatic frame_result_type deframe_byte(input logic [7:0] c);
      frame_result_type r;
      int unsigned held;
      int d;
      logic ok;
      logic [15:0] rx;
      r = '0;
      if (!in_frame_m) begin
         if (c == CH_AT) begin
            open_frame();
            r.ev = EV_START;
         end else begin
            tally[CNT_DROPPED] += 1;
            r.ev = EV_DROPPED;
         end
      end else if (c == CH_AT) begin
         tally[CNT_FORMAT] += 1;
         open_frame();
         r.ev = EV_RESTART;
      end else if (frame_len >= MAX_LEN - 1) begin
         tally[CNT_OVERFLOW] += 1;
         in_frame_m = 1'b0;
         frame_len = 0;
         r.ev = EV_OVERFLOW;
      end else begin
         held = frame_len - 1;
         if (held >= DELAY) begin
            r.pv = 1'b1;
            r.pbyte = tail_q[0];
            r.pidx = 8'(held - DELAY);
            crc_acc = crc_update(crc_acc, tail_q[0]);
         end
         for (int k = 0; k < DELAY - 1; k++) tail_q[k] = tail_q[k + 1];
         tail_q[DELAY - 1] = c;
         frame_len++;
         r.ev = EV_STORED;
         if (c == CH_LF) begin
            ok = (frame_len >= 9) && tail_q[0] == CH_STAR && tail_q[5] == CH_CR;
            rx = '0;
            for (int k = 1; k <= 4; k++) begin
               d = hex_val(tail_q[k]);
               if (d < 0) ok = 1'b0;
               else rx = {rx[11:0], 4'(d)};
            end
            if (ok) begin
               r.plen = 8'(frame_len - 8);
               r.rcrc = rx;
               r.ccrc = crc_acc;
               if (rx == crc_acc) begin
                  tally[CNT_VALID] += 1;
                  r.ev = EV_VALID;
               end else begin
                  tally[CNT_CRC] += 1;
                  r.ev = EV_CRC_ERR;
               end
            end else begin
               tally[CNT_FORMAT] += 1;
               r.ev = EV_FORMAT;
            end
            in_frame_m = 1'b0;
            frame_len = 0;
         end
      end
      r.n_valid = tally[CNT_VALID];
      r.n_crc = tally[CNT_CRC];
      r.n_format = tally[CNT_FORMAT];
      r.n_ovf = tally[CNT_OVERFLOW];
      r.n_drop = tally[CNT_DROPPED];
      return r;
   endfunction

   task automatic note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got)
         note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
   endtask

   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            note_failure("result transaction with nothing outstanding");
         end else begin
            want = due_results.pop_front();
            compare_field("event_res", want.ev, rsp_event_res);
            compare_field("payload_valid", want.pv, rsp_payload_valid);
            compare_field("payload_byte", want.pbyte, rsp_payload_byte);
            compare_field("payload_index", want.pidx, rsp_payload_index);
            compare_field("body_len", want.plen, rsp_body_len);
            compare_field("crc_rx", want.rcrc, rsp_crc_rx);
            compare_field("crc_calc", want.ccrc, rsp_crc_calc);
            compare_field("valid_total", want.n_valid, rsp_valid_total);
            compare_field("crc_error_total", want.n_crc, rsp_crc_error_total);
            compare_field("format_error_total", want.n_format, rsp_format_error_total);
            compare_field("overflow_total", want.n_ovf, rsp_overflow_total);
            compare_field("dropped_total", want.n_drop, rsp_dropped_total);
         end
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      due_results.push_back(deframe_byte(b));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte_except(input logic [7:0] x);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == x || b == CH_AT || b == CH_LF);
      return b;
   endfunction

   function automatic void make_body(output logic [7:0] body[$], input int len);
      body = {};
      repeat (len) body.push_back(pick_byte_except(CH_AT));
   endfunction

   task automatic send_frame(input logic [7:0] body[$], input flaw_type flaw);
      logic [7:0] txt[$];
      logic [15:0] crc;
      logic [7:0] bad_hex [5] = '{8'h2F, 8'h3A, 8'h47, 8'h60, 8'h67};
      int spot;
      crc = CRC_INIT;
      txt.push_back(CH_AT);
      foreach (body[i]) begin
         txt.push_back(body[i]);
         crc = crc_update(crc, body[i]);
      end
      if (flaw == FLAW_CRC) crc ^= 16'($urandom_range(1, 'hFFFF));
      txt.push_back(flaw == FLAW_STAR ? pick_byte_except(CH_STAR) : CH_STAR);
      for (int k = 3; k >= 0; k--) begin
         logic [3:0] nib;
         nib = crc[4*k +: 4];
         if (nib < 10) txt.push_back(8'h30 + nib);
         else txt.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
      end
      if (flaw == FLAW_HEX)
         txt[txt.size() - 1 - $urandom_range(0, 3)] = bad_hex[$urandom_range(0, 4)];
      txt.push_back(flaw == FLAW_CR ? pick_byte_except(CH_CR) : CH_CR);
      txt.push_back(CH_LF);
      if (flaw == FLAW_RESTART) txt.insert($urandom_range(1, txt.size() - 1), CH_AT);
      if (flaw == FLAW_SHORT) begin
         spot = $urandom_range(1, txt.size() - 2);
         while (txt.size() > spot) void'(txt.pop_back());
         txt.push_back(CH_LF);
      end
      foreach (txt[i]) send_byte(txt[i]);
   endtask

   // extremes, restart into a one-byte zero payload, bare close, CRC error
   task automatic test_directed();
      logic [7:0] body[$];
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_AT);
      body = '{8'h00};
      send_frame(body, FLAW_NONE);
      send_byte(CH_AT);
      send_byte(CH_LF);
      body = '{8'hFF};
      send_frame(body, FLAW_CRC);
      drain();
   endtask

   // longest valid payload, overflow on the closing byte, overflow then dropped tail
   task automatic test_long_frames();
      logic [7:0] body[$];
      make_body(body, MAX_LEN - 9);
      send_frame(body, FLAW_NONE);
      make_body(body, MAX_LEN - 8);
      send_frame(body, FLAW_NONE);
      make_body(body, MAX_LEN + 4);
      send_frame(body, FLAW_NONE);
      drain();
   endtask

   task automatic test_backpressure();
      logic [7:0] body[$];
      idle_pct = 0;
      stall_pct = 0;
      hold_req <= hold_req + 1;
      make_body(body, 12);
      send_frame(body, FLAW_NONE);
      make_body(body, 20);
      send_frame(body, FLAW_NONE);
      drain();
      make_body(body, 5);
      send_frame(body, FLAW_CRC);
      drain();
   endtask

   task automatic test_random(input int n_bytes, input int send_idle, input int recv_stall);
      logic [7:0] body[$];
      int target;
      int k;
      int len;
      idle_pct = send_idle;
      stall_pct = recv_stall;
      target = items_sent + n_bytes;
      while (items_sent < target) begin
         k = $urandom_range(0, 99);
         len = $urandom_range(0, 99);
         len = len < 5 ? 0 : len < 93 ? $urandom_range(1, 16) :
               len < 98 ? $urandom_range(17, 64) : $urandom_range(200, 254);
         make_body(body, len);
         if (k < 70) send_frame(body, FLAW_NONE);
         else if (k < 88) send_frame(body, flaw_type'($urandom_range(FLAW_CRC, FLAW_SHORT)));
         else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      drain();
   endtask

   initial begin
      int w;
      foreach (tally[i]) tally[i] = '0;
      foreach (tail_q[i]) tail_q[i] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_frames();
      test_backpressure();
      test_random(110, 0, 0);
      test_random(110, 81, 0);
      test_random(110, 0, 81);
      test_random(110, 18, 18);
      for (w = 0; w < 20000 && due_results.size() != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (due_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", due_results.size()));
      $display("Sent %0d bytes: %0d valid, %0d CRC error, %0d format error,",
               items_sent, tally[CNT_VALID], tally[CNT_CRC], tally[CNT_FORMAT]);
      $display("%0d overflow, %0d dropped; idle/stall phases 0, 81 and 18 per cent",
               tally[CNT_OVERFLOW], tally[CNT_DROPPED]);
      $display("plus a %0d-cycle receiver hold-off", HOLD_CYCLES);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out");
      $display("Mismatches found");
      $finish;
   end

endmodule
